// File: hdl/hkol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkol_pkg
// Shared types and constants of the held key order list: stream field
// widths, controller states and the command and status groups.
// ----------------------------------------------------------------------------
package hkol_pkg;

  localparam int KEY_W        = 8;
  localparam int COUNT_W      = 4;
  localparam int SLOT_OUTPUTS = 10;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_PAYLOAD_W = COUNT_W + SLOT_OUTPUTS * KEY_W;
  localparam int OUT_DATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;

  localparam logic REQ_PRESS   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_PUSH
  } hkol_state_t;

  typedef struct packed {
    logic load_req;
    logic clr_idx;
    logic inc_idx;
    logic append;
    logic shift;
    logic finish;
    logic load_out;
  } hkol_cmd_t;

  typedef struct packed {
    logic code_zero;
    logic is_release;
    logic at_end;
    logic at_last;
    logic match;
    logic full;
    logic out_free;
  } hkol_sts_t;

endpackage

// File: hdl/hkol_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkol_ctrl
// Sequencer for one request: search the list, append a new code or close
// the gap entry by entry, then hand the updated list to the output register.
// ----------------------------------------------------------------------------
module hkol_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  hkol_pkg::hkol_sts_t sts,
  output hkol_pkg::hkol_cmd_t cmd
);

  hkol_pkg::hkol_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hkol_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      hkol_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          cmd.clr_idx  = 1'b1;
          state_nxt    = hkol_pkg::ST_SEARCH;
        end
      end
      hkol_pkg::ST_SEARCH: begin
        if (sts.code_zero) begin
          state_nxt = hkol_pkg::ST_PUSH;
        end else if (sts.at_end) begin
          // not held: only a press with room left changes the list
          cmd.append = !sts.is_release && !sts.full;
          state_nxt  = hkol_pkg::ST_PUSH;
        end else if (sts.match) begin
          state_nxt = hkol_pkg::ST_SHIFT;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      hkol_pkg::ST_SHIFT: begin
        if (sts.at_last) begin
          cmd.finish = 1'b1;
          state_nxt  = hkol_pkg::ST_PUSH;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      hkol_pkg::ST_PUSH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = hkol_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hkol_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/hkol_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkol_dp
// List storage, walk index, entry count and the output register that
// holds one finished result.
// ----------------------------------------------------------------------------
module hkol_dp #(
  parameter int LIST_DEPTH = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tuser,
  input  logic [hkol_pkg::IN_DATA_W-1:0]  in_tdata,
  input  hkol_pkg::hkol_cmd_t             cmd,
  output hkol_pkg::hkol_sts_t             sts,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hkol_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int KW    = hkol_pkg::KEY_W;

  logic [KW-1:0]    keys_r   [LIST_DEPTH];
  logic [KW-1:0]    keys_nxt [LIST_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W:0]   idx_inc;
  logic [CNT_W-1:0] rd_addr, wr_addr;
  logic [KW-1:0]    rd_data, wr_data;
  logic             wr_en;
  logic             release_r;
  logic [KW-1:0]    code_r;
  logic             out_valid_r;
  logic [hkol_pkg::OUT_DATA_W-1:0] out_data_r, payload;

  assign idx_inc = {1'b0, idx_r} + 1'b1;
  // while shifting, the entry behind the current one moves forward
  assign rd_addr = cmd.shift ? idx_inc[CNT_W-1:0] : idx_r;

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (rd_addr == CNT_W'(i)) begin
        rd_data = keys_r[i];
      end
    end
  end

  assign wr_en   = cmd.append | cmd.shift | cmd.finish;
  assign wr_addr = cmd.append ? cnt_r : idx_r;
  assign wr_data = cmd.append ? code_r :
                   cmd.shift  ? rd_data :
                   (release_r == hkol_pkg::REQ_RELEASE) ? '0 : code_r;

  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      keys_nxt[i] = keys_r[i];
      if (wr_en && (wr_addr == CNT_W'(i))) begin
        keys_nxt[i] = wr_data;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.append) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.finish && (release_r == hkol_pkg::REQ_RELEASE)) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.clr_idx) begin
      idx_nxt = '0;
    end else if (cmd.inc_idx || cmd.shift) begin
      idx_nxt = idx_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // entries at or past the count are never read, so storage needs no reset
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      keys_r[i] <= keys_nxt[i];
    end
    if (cmd.load_req) begin
      release_r <= in_tuser;
      code_r    <= in_tdata[KW-1:0];
    end
    if (cmd.load_out) begin
      out_data_r <= payload;
    end
  end

  assign payload[hkol_pkg::COUNT_W-1:0] = hkol_pkg::COUNT_W'(cnt_r);
  assign payload[hkol_pkg::OUT_DATA_W-1:hkol_pkg::OUT_PAYLOAD_W] = '0;

  for (genvar j = 0; j < hkol_pkg::SLOT_OUTPUTS; j++) begin : g_slot
    if (j < LIST_DEPTH) begin : g_used
      assign payload[hkol_pkg::COUNT_W + j*KW +: KW] =
        (CNT_W'(j) < cnt_r) ? keys_r[j] : '0;
    end else begin : g_unused
      assign payload[hkol_pkg::COUNT_W + j*KW +: KW] = '0;
    end
  end

  assign sts.code_zero  = (code_r == '0);
  assign sts.is_release = (release_r == hkol_pkg::REQ_RELEASE);
  assign sts.at_end     = (idx_r == cnt_r);
  assign sts.at_last    = (idx_inc >= {1'b0, cnt_r});
  assign sts.match      = (rd_data == code_r);
  assign sts.full       = (cnt_r == CNT_W'(LIST_DEPTH));
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(LIST_DEPTH))
    else $error("held count above list depth");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> !sts.full)
    else $error("append into a full list");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.append, cmd.shift, cmd.finish}))
    else $error("more than one list write in a cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result overwritten before it was taken");

  a_release_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && sts.is_release) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("release of a held key did not shrink the list");
`endif

endmodule

// File: hdl/held_key_order_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// held_key_order_list
// Ordered list of held key codes, oldest first, updated per key request.
// ----------------------------------------------------------------------------
// Input channel (in_*): one key request per transfer, in_tuser = 0 for a
// press and 1 for a release, in_tdata = key code. Code 0 changes nothing.
// A press of a new code appends it (ignored when the list is full), a press
// of a held code moves it to the end, a release removes it and closes up.
// Output channel (out_*): one result per request, carrying the held count
// and ten slots, oldest first, empty slots as 0.
// Timing: a request is taken in ST_IDLE, then the list is walked one entry
// per cycle until the code is found or the end is passed (code 0 skips the
// walk); for a held code the walk goes on from there, one entry per cycle,
// to close the gap. The result is then loaded in ST_PUSH, and only after
// that is the next request taken. The single read port on the list is why
// the walk goes one entry at a time.
// The result sits in an output register: if the receiver stalls, the next
// request is still accepted and processed, and waits only to load its result.
// Reset empties the list and drops any pending result.
// ----------------------------------------------------------------------------
module held_key_order_list #(
  parameter int LIST_DEPTH = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hkol_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] key_code
  input  logic                            in_tuser,   // [0] req_type
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [3:0] held_count, [11:4] slot_0, [19:12] slot_1 ... [83:76] slot_9, [87:84] zero
  output logic [hkol_pkg::OUT_DATA_W-1:0] out_tdata
);

  hkol_pkg::hkol_cmd_t cmd;
  hkol_pkg::hkol_sts_t sts;

  hkol_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hkol_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: test/held_keys_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// held_keys_checker
// Watches both streams of the held key order list. Every accepted key
// request is run through a local copy of the held list, and the list it
// leaves behind is queued. Every accepted result is compared field by
// field with the oldest queued list. Failures are counted for the top.
// ----------------------------------------------------------------------------
module held_keys_checker #(
  parameter int LIST_DEPTH = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [hkol_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] key_code
  input  logic                            in_tuser,   // [0] req_type
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [3:0] held_count, [11:4] slot_0 ... [83:76] slot_9, [87:84] zero
  input  logic [hkol_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              pending
);

  localparam logic [hkol_pkg::KEY_W-1:0] NO_KEY = '0;

  typedef struct packed {
    logic [hkol_pkg::COUNT_W-1:0]                               count;
    logic [hkol_pkg::SLOT_OUTPUTS-1:0][hkol_pkg::KEY_W-1:0]     slots;
  } held_view_t;

  logic [hkol_pkg::KEY_W-1:0] held_list [LIST_DEPTH];
  int                         held_n;
  held_view_t                 expected_lists [$];

  // update the local list for one request and return what the block shows
  function automatic held_view_t apply_key_request(input logic rel,
                                                   input logic [hkol_pkg::KEY_W-1:0] code);
    held_view_t view;
    int         pos;
    int         i;
    pos = -1;
    if (code != NO_KEY) begin
      for (i = 0; i < held_n; i++) begin
        if (pos < 0 && held_list[i] == code) pos = i;
      end
      if (rel == hkol_pkg::REQ_PRESS) begin
        if (pos >= 0) begin
          for (i = pos; i < held_n - 1; i++) held_list[i] = held_list[i + 1];
          held_list[held_n - 1] = code;
        end else if (held_n < LIST_DEPTH) begin
          held_list[held_n] = code;
          held_n++;
        end
      end else if (pos >= 0) begin
        for (i = pos; i < held_n - 1; i++) held_list[i] = held_list[i + 1];
        held_list[held_n - 1] = NO_KEY;
        held_n--;
      end
    end
    view.count = held_n[hkol_pkg::COUNT_W-1:0];
    for (i = 0; i < hkol_pkg::SLOT_OUTPUTS; i++) begin
      view.slots[i] = (i < LIST_DEPTH && i < held_n) ? held_list[i] : NO_KEY;
    end
    return view;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    held_view_t                 want;
    logic [hkol_pkg::KEY_W-1:0] got_slot;
    if (!rst_n) begin
      for (int k = 0; k < LIST_DEPTH; k++) held_list[k] = NO_KEY;
      held_n = 0;
      expected_lists.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_lists.size() == 0) begin
          $error("result with no request outstanding: %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_lists.pop_front();
          if (out_tdata[hkol_pkg::COUNT_W-1:0] !== want.count) begin
            $error("held_count: expected %0d, actual %0d", want.count,
                   out_tdata[hkol_pkg::COUNT_W-1:0]);
            fail_count++;
          end
          for (int j = 0; j < hkol_pkg::SLOT_OUTPUTS; j++) begin
            got_slot = out_tdata[hkol_pkg::COUNT_W + hkol_pkg::KEY_W*j +: hkol_pkg::KEY_W];
            if (got_slot !== want.slots[j]) begin
              $error("slot_%0d: expected %0d, actual %0d", j, want.slots[j], got_slot);
              fail_count++;
            end
          end
          if (out_tdata[hkol_pkg::OUT_DATA_W-1:hkol_pkg::OUT_PAYLOAD_W] !== '0) begin
            $error("pad: expected 0, actual %0d",
                   out_tdata[hkol_pkg::OUT_DATA_W-1:hkol_pkg::OUT_PAYLOAD_W]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_lists.push_back(apply_key_request(in_tuser, in_tdata[hkol_pkg::KEY_W-1:0]));
      end
    end
    pending = expected_lists.size();
  end

endmodule

// File: test/held_key_order_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// held_key_order_list_tb
// Drives key press and release requests into the held key order list with
// random gaps on both streams: a directed opening (empty list, full list,
// code zero, moves and removals at both ends), then random key sessions
// drawn from small code pools so the list fills, churns and drains.
// Checking is done by held_keys_checker.
// ----------------------------------------------------------------------------
module held_key_order_list_tb;

  localparam int LIST_DEPTH  = 10;
  localparam int RANDOM_KEYS = 590;
  localparam int CYCLE_LIMIT = 300000;
  localparam int POOL_SIZE   = 14;
  localparam logic [hkol_pkg::KEY_W-1:0] NO_KEY = '0;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [hkol_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [hkol_pkg::OUT_DATA_W-1:0] out_tdata;
  int                              fail_count;
  int                              pending;
  int                              cycles;
  bit                              quiet;   // no gaps on either side

  held_key_order_list #(.LIST_DEPTH(LIST_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  held_keys_checker #(.LIST_DEPTH(LIST_DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stall before each result
  initial begin
    int stall;
    out_tready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic send_key(input logic rel, input logic [hkol_pkg::KEY_W-1:0] code);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rel;
    in_tdata  <= code;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    logic [hkol_pkg::KEY_W-1:0] pool [POOL_SIZE];
    logic [hkol_pkg::KEY_W-1:0] code;
    logic                       rel;
    int                         press_pct;
    int                         useful;
    int                         sent;
    int                         pick;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = hkol_pkg::REQ_PRESS;
    in_tdata  = '0;
    quiet     = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: code zero and a release of a code never held
    send_key(hkol_pkg::REQ_PRESS, NO_KEY);
    send_key(hkol_pkg::REQ_RELEASE, NO_KEY);
    send_key(hkol_pkg::REQ_RELEASE, 8'd5);
    // fill to the top, every code bit seen high and low
    send_key(hkol_pkg::REQ_PRESS, 8'd1);
    send_key(hkol_pkg::REQ_PRESS, 8'd255);
    send_key(hkol_pkg::REQ_PRESS, 8'd128);
    send_key(hkol_pkg::REQ_PRESS, 8'd127);
    send_key(hkol_pkg::REQ_PRESS, 8'd2);
    send_key(hkol_pkg::REQ_PRESS, 8'd4);
    send_key(hkol_pkg::REQ_PRESS, 8'd8);
    send_key(hkol_pkg::REQ_PRESS, 8'd16);
    send_key(hkol_pkg::REQ_PRESS, 8'd32);
    send_key(hkol_pkg::REQ_PRESS, 8'd64);
    // full list: new code dropped, held codes moved to the end
    send_key(hkol_pkg::REQ_PRESS, 8'd85);
    send_key(hkol_pkg::REQ_PRESS, 8'd1);
    send_key(hkol_pkg::REQ_PRESS, 8'd1);
    send_key(hkol_pkg::REQ_PRESS, NO_KEY);
    // removals at the front, back and middle
    send_key(hkol_pkg::REQ_RELEASE, 8'd255);
    send_key(hkol_pkg::REQ_RELEASE, 8'd1);
    send_key(hkol_pkg::REQ_RELEASE, 8'd8);
    send_key(hkol_pkg::REQ_RELEASE, 8'd85);
    send_key(hkol_pkg::REQ_PRESS, 8'd170);

    useful    = 0;
    sent      = 0;
    press_pct = 50;
    while (useful < RANDOM_KEYS) begin
      // new session every 60 requests: fresh pool, press bias, gap mode
      if (sent % 60 == 0) begin
        for (int k = 0; k < POOL_SIZE; k++) pool[k] = 8'($urandom_range(1, 255));
        case ($urandom_range(0, 3))
          0: press_pct = 30;
          1: press_pct = 50;
          2: press_pct = 70;
          default: press_pct = 85;
        endcase
        quiet = ($urandom_range(0, 3) == 0);
      end
      rel  = ($urandom_range(0, 99) < press_pct) ? hkol_pkg::REQ_PRESS : hkol_pkg::REQ_RELEASE;
      pick = $urandom_range(0, 99);
      if (pick < 7)       code = NO_KEY;
      else if (pick < 11) code = 8'($urandom_range(0, 255));
      else                code = pool[$urandom_range(0, POOL_SIZE - 1)];
      send_key(rel, code);
      sent++;
      if (code != NO_KEY) useful++;
    end
    in_tvalid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (2 * LIST_DEPTH + 4) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
